// ----- sv/ptd_pkg.sv -----
// Package for the pod tube dynamics step block: constants, codes, types.
// No dependencies; compile first.
package ptd_pkg;

	localparam int TIME_SHIFT = 10;
	localparam int CFG_W      = 32;
	localparam int IDX_W      = 3;
	localparam int DIV_W      = 31;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic signed [32:0] LS_MIN  = 33'sd131;
	localparam logic signed [32:0] LS_MAX  = 33'sd65536;
	localparam logic signed [31:0] POS_MIN = -32'sd655;

	typedef enum logic [IDX_W-1:0] {
		REG_DRAG_FACTOR  = 3'd0,
		REG_BRAKE_FACTOR = 3'd1,
		REG_PUSH_ACCEL   = 3'd2,
		REG_PUSH_END     = 3'd3,
		REG_TUBE_LENGTH  = 3'd4,
		REG_FID_START    = 3'd5,
		REG_FID_PITCH    = 3'd6,
		REG_FID_WIDTH    = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_HI, S_LO, S_BRK, S_SUM, S_UPD, S_DIV, S_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] rem;
	} div_res_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		if (x > 50'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (x < -50'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

// ----- sv/ptd_if.sv -----
// Channel interfaces for input ticks and result beats.
// Depends on nothing; compile after ptd_pkg.
interface ptd_in_if;
	logic               valid;
	logic               ready;
	logic               restart;
	logic               push_on_restart;
	logic [15:0]        brake_force;
	logic               low_speed_enable;
	logic signed [31:0] low_speed_target;

	modport source(output valid, restart, push_on_restart, brake_force,
		low_speed_enable, low_speed_target, input ready);
	modport sink(input valid, restart, push_on_restart, brake_force,
		low_speed_enable, low_speed_target, output ready);
endinterface

interface ptd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_out;
	logic signed [31:0] velocity_out;
	logic signed [31:0] accel_out;
	logic               fiducial_seen;
	logic               collided;

	modport source(output valid, position_out, velocity_out, accel_out,
		fiducial_seen, collided, input ready);
	modport sink(input valid, position_out, velocity_out, accel_out,
		fiducial_seen, collided, output ready);
endinterface

// ----- sv/ptd_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
// No package dependencies.
module ptd_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end
endmodule

// ----- sv/ptd_div.sv -----
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on ptd_pkg for the request and result structs.
module ptd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ptd_pkg::div_req_t req,
	output ptd_pkg::div_res_t res
);
	import ptd_pkg::*;

	logic [DIV_W-1:0]     rem_q, dvd_q, dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// keep the trial only when the divisor does not fit
			rem_q <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.rem  = rem_q;
endmodule

// ----- sv/pod_tube_dynamics_step_top.sv -----
// Top level of the pod tube dynamics step: sequencer, state and registers.
// Depends on ptd_pkg, ptd_if, ptd_mul and ptd_div.
//
//  channel  dir  beat contents
//  in_ch    in   restart, push_on_restart, brake_force, low_speed_*
//  out_ch   out  position_out, velocity_out, accel_out, fiducial_seen, collided
//  cfg_*    in   one register write per cycle with cfg_we high
//
// A normal tick runs from one accept to the next through four passes
// through the shared multiplier, a summing step, the Euler update, the
// remainder step (shift-subtract per dividend bit, then done) and write-back.
// Without a remainder (new position not past the first mark, or zero
// pitch) that step is skipped. Restart and collision ticks go to write-back.
// in_ch.ready is high only while the sequencer is idle; a result waiting on
// out_ch does not block the next accept, only the next write-back.
// Reset is asynchronous, clears the pod state and restores the configuration.
module pod_tube_dynamics_step_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ptd_pkg::CFG_W-1:0]     cfg_data,
	ptd_in_if.sink                        in_ch,
	ptd_out_if.source                     out_ch
);
	import ptd_pkg::*;

	// configuration
	logic [31:0]        drag_q, brkf_q;
	logic [30:0]        push_acc_q, tube_q, fstart_q, fpitch_q, fwidth_q;
	logic signed [31:0] push_end_q;

	// pod state
	logic signed [31:0] pos_q, vel_q, acc_q;
	logic               armed_q, fid_q;

	// latched tick and working values
	logic [15:0]        force_q;
	logic               lse_q;
	logic signed [31:0] tgt_q;
	logic [31:0]        v2_q;
	logic [63:0]        hp_q;
	logic [47:0]        drag_mag_q;
	logic               coll_q;

	// result register
	logic               ov_q, ofid_q, ocoll_q;
	logic signed [31:0] opos_q, ovel_q, oacc_q;

	state_t state_q, state_d;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	div_req_t    dreq;
	div_res_t    dres;

	logic               accept, out_free;
	logic               collide_now;
	logic [31:0]        av;
	logic [63:0]        p_sum;
	logic signed [49:0] brake, low, total;
	logic signed [32:0] err;
	logic signed [31:0] new_pos, new_vel;
	logic signed [32:0] fid_off;
	logic [30:0]        rem_fix;

	ptd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));
	ptd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .res(dres));

	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !ov_q || out_ch.ready;
	assign collide_now = ($signed({pos_q[31], pos_q}) > $signed({2'b0, tube_q}))
		|| (pos_q < POS_MIN);
	assign av          = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
	assign p_sum       = hp_q + {32'b0, prod_q[63:32]};

	// brake opposes motion, none at rest
	always_comb begin
		brake = '0;
		if (vel_q > 0)
			brake = -$signed({18'b0, prod_q[47:16]});
		else if (vel_q < 0)
			brake = $signed({18'b0, prod_q[47:16]});
	end

	// low-speed loop, zero error takes the negative branch
	assign err = 33'(tgt_q) - 33'(vel_q);
	always_comb begin
		low = '0;
		if (lse_q) begin
			if (err > 0)
				low = 50'(err > LS_MAX ? LS_MAX : (err < LS_MIN ? LS_MIN : err));
			else
				low = 50'(err < -LS_MAX ? -LS_MAX : (err > -LS_MIN ? -LS_MIN : err));
		end
	end

	assign total = ((armed_q && pos_q < push_end_q) ? $signed({19'b0, push_acc_q}) : 50'sd0)
		- $signed({2'b0, drag_mag_q}) + brake + low;

	assign new_pos = sat32(50'(pos_q) + 50'(vel_q >>> TIME_SHIFT));
	assign new_vel = sat32(50'(vel_q) + 50'(acc_q >>> TIME_SHIFT));
	// offset of the new position from the first mark, valid in the update step
	assign fid_off = 33'(new_pos) - $signed({2'b0, fstart_q});
	assign rem_fix = (dres.rem == '0) ? fpitch_q : dres.rem;

	// multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ:  begin mul_a = av;              mul_b = av;     end
			S_HI:  begin mul_a = prod_q[63:32];   mul_b = drag_q; end
			S_LO:  begin mul_a = v2_q;            mul_b = drag_q; end
			S_BRK: begin mul_a = {16'b0, force_q}; mul_b = brkf_q; end
			default: ;
		endcase
	end

	always_comb begin
		dreq.start    = (state_q == S_UPD) && (fid_off > 0) && (fpitch_q != '0);
		dreq.dividend = fid_off[30:0];
		dreq.divisor  = fpitch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (in_ch.restart || collide_now)
						state_d = S_FIN;
					else
						state_d = S_SQ;
				end
			end
			S_SQ:  state_d = S_HI;
			S_HI:  state_d = S_LO;
			S_LO:  state_d = S_BRK;
			S_BRK: state_d = S_SUM;
			S_SUM: state_d = S_UPD;
			S_UPD: state_d = dreq.start ? S_DIV : S_FIN;
			S_DIV: if (dres.done) state_d = S_FIN;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q     <= '0;
			brkf_q     <= '0;
			push_acc_q <= '0;
			push_end_q <= '0;
			tube_q     <= 31'h7FFFFFFF;
			fstart_q   <= '0;
			fpitch_q   <= 31'd65536;
			fwidth_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DRAG_FACTOR:  drag_q     <= cfg_data;
				REG_BRAKE_FACTOR: brkf_q     <= cfg_data;
				REG_PUSH_ACCEL:   push_acc_q <= cfg_data[30:0];
				REG_PUSH_END:     push_end_q <= $signed(cfg_data);
				REG_TUBE_LENGTH:  tube_q     <= cfg_data[30:0];
				REG_FID_START:    fstart_q   <= cfg_data[30:0];
				REG_FID_PITCH:    fpitch_q   <= cfg_data[30:0];
				REG_FID_WIDTH:    fwidth_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// pod state and sequencing of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vel_q   <= '0;
			acc_q   <= '0;
			armed_q <= 1'b0;
			fid_q   <= 1'b0;
			coll_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// load a new beat, or drop the one just taken
			if (state_q == S_FIN && out_free)
				ov_q <= 1'b1;
			else if (ov_q && out_ch.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					coll_q <= !in_ch.restart && collide_now;
					if (in_ch.restart) begin
						pos_q   <= '0;
						vel_q   <= '0;
						acc_q   <= '0;
						armed_q <= in_ch.push_on_restart;
						fid_q   <= 1'b0;
					end
				end
				S_SUM: begin
					acc_q <= sat32(total);
					// reaching the push end disarms the pusher
					if (armed_q && !(pos_q < push_end_q))
						armed_q <= 1'b0;
				end
				S_UPD: begin
					pos_q <= new_pos;
					vel_q <= new_vel;
					if (!(fid_off > 0))
						fid_q <= 1'b0;
					else if (fpitch_q == '0)
						fid_q <= fid_off[30:0] < fwidth_q;
				end
				S_DIV: if (dres.done) fid_q <= rem_fix < fwidth_q;
				default: ;
			endcase
		end
	end

	// tick operands and products; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			force_q <= in_ch.brake_force;
			lse_q   <= in_ch.low_speed_enable;
			tgt_q   <= in_ch.low_speed_target;
		end
		if (state_q == S_HI)
			v2_q <= prod_q[31:0];
		if (state_q == S_LO)
			hp_q <= prod_q;
		if (state_q == S_BRK)
			drag_mag_q <= p_sum[63:16];
		if (state_q == S_FIN && out_free) begin
			opos_q  <= pos_q;
			ovel_q  <= vel_q;
			oacc_q  <= acc_q;
			ofid_q  <= fid_q;
			ocoll_q <= coll_q;
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.position_out  = opos_q;
	assign out_ch.velocity_out  = ovel_q;
	assign out_ch.accel_out     = oacc_q;
	assign out_ch.fiducial_seen = ofid_q;
	assign out_ch.collided      = ocoll_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("block still ready after accepting a tick");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		dres.done |-> state_q == S_DIV)
		else $error("remainder finished outside its step");

	a_frozen_on_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && coll_q && out_free) |=>
		(out_ch.position_out == pos_q && out_ch.fiducial_seen == fid_q))
		else $error("collision beat does not repeat stored state");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dres.busy |-> !dreq.start)
		else $error("remainder restarted while busy");
`endif
endmodule
